[rtl/hcb_pkg.sv]
// Shared types, constants and codes of the Huffman code builder.
package hcb_pkg;

  localparam int MAX_SYMBOLS_DEF = 32;
  localparam int WEIGHT_W        = 16;
  localparam int IDX_W           = 5;
  localparam int LEN_W           = 5;
  localparam int CODE_W          = 62;
  localparam int RADIX_W         = 2;
  localparam int DIGIT_W         = 2;

  localparam logic [RADIX_W-1:0] RADIX_TERNARY = 2'd3;
  localparam logic [RADIX_W-1:0] RADIX_RESET   = 2'd2;
  localparam logic [LEN_W-1:0]   LEN_MAX       = 5'd31;
  localparam logic [LEN_W-1:0]   LEN_LONE      = 5'd1;
  localparam logic [1:0]         GROUP_BIN     = 2'd2;
  localparam logic [1:0]         GROUP_TER     = 2'd3;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP,
    CMD_CLEAR
  } cell_cmd_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_PAD,
    S_SNAP,
    S_MERGE,
    S_PUSH,
    S_ROOT,
    S_NEXT,
    S_WALK,
    S_STEP,
    S_OUT,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                last_symbol;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  symbol_index;
    logic [LEN_W-1:0]  code_length;
    logic [CODE_W-1:0] codeword;
    logic              overflow;
    logic              last_result;
  } out_t;

endpackage

[rtl/huffman_code_builder_core.sv]
// Top level of the Huffman code builder: load, tree build and code emission.
//
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one symbol weight per cycle
//   while loading; an item with last_symbol set closes the set. Symbols past
//   MAX_SYMBOLS are dropped and flagged in the overflow field of the results.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes radix: 3 selects
//   ternary digits, anything else binary. Write it only between sets.
//   out channel (out_valid/out_ready/out_data) returns one result per loaded
//   symbol, largest weight first, ties by load order; last_result marks the
//   final one, after which in_ready rises again for the next set.
// Operation:
//   Each weight is sorted into a chain of cells as it arrives. The build
//   merges group nodes at a time, group being 2 or 3. Each result is built
//   one code digit at a time, as the walk reads one parent link per RAM read.
//   A stalled receiver holds the result register and the whole walk; no
//   input is taken until the last result of a set is transferred.
// Reset: synchronous; clears the chain, the symbol count, the overflow flag and radix (back to 2).
module huffman_code_builder_core #(
  parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hcb_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hcb_pkg::out_t                out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hcb_pkg::RADIX_W-1:0]  cfg_data
);

  import hcb_pkg::*;

  localparam int CELLS      = MAX_SYMBOLS + 1;
  localparam int POS_W      = $clog2(MAX_SYMBOLS);
  localparam int CNT_W      = $clog2(MAX_SYMBOLS + 2);
  localparam int NODE_DEPTH = 2 * MAX_SYMBOLS;
  localparam int ID_W       = $clog2(NODE_DEPTH);
  localparam int W_W        = WEIGHT_W + $clog2(MAX_SYMBOLS);

  state_t state, state_next;

  logic [RADIX_W-1:0] radix;
  logic [CNT_W-1:0]   count;
  logic               ovf;
  logic [CNT_W-1:0]   leaves;
  logic [CNT_W-1:0]   cnt;
  logic [ID_W-1:0]    nxt;
  logic [1:0]         k;
  logic [W_W-1:0]     sum;
  logic [ID_W-1:0]    root;
  logic [POS_W-1:0]   epos;
  logic [CNT_W-1:0]   em;
  logic [ID_W-1:0]    nd;
  logic [LEN_W-1:0]   len;
  logic [CODE_W-1:0]  code;
  logic [ID_W-1:0]    emit_id [MAX_SYMBOLS];

  logic [CELLS-1:0]   cell_valid;
  logic [CELLS-1:0]   cell_lt;
  logic [W_W-1:0]     cell_w  [CELLS];
  logic [ID_W-1:0]    cell_id [CELLS];

  cell_cmd_t          cmd;
  logic [W_W-1:0]     new_w;
  logic [ID_W-1:0]    new_id;

  logic               ternary;
  logic [1:0]         group;
  logic               accept;
  logic               room;
  logic               pad;
  logic               walk_done;
  logic               last_emit;
  logic               ram_we;
  logic               ram_re;
  logic [ID_W+1:0]    ram_rdata;
  logic [DIGIT_W-1:0] digit;
  logic [ID_W-1:0]    parent;
  logic [5:0]         shift;

  assign ternary   = (radix == RADIX_TERNARY);
  assign group     = ternary ? GROUP_TER : GROUP_BIN;
  assign in_ready  = (state == S_LOAD);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign room      = (count < CNT_W'(MAX_SYMBOLS));
  assign pad       = ternary && !count[0];
  assign walk_done = (nd == root) || (len == LEN_MAX);
  assign last_emit = (em == count - CNT_W'(1));
  assign ram_we    = (state == S_MERGE);
  assign ram_re    = (state == S_WALK) && !walk_done;
  assign digit     = ram_rdata[DIGIT_W-1:0];
  assign parent    = ram_rdata[ID_W+1:2];
  assign shift     = ternary ? {len, 1'b0} : {1'b0, len};

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    logic            lo_valid, lo_lt, up_valid;
    logic [W_W-1:0]  lo_w, up_w;
    logic [ID_W-1:0] lo_id, up_id;
    if (j == 0) begin : g_bot
      assign lo_valid = 1'b0;
      assign lo_lt    = 1'b1;
      assign lo_w     = '0;
      assign lo_id    = '0;
    end else begin : g_mid
      assign lo_valid = cell_valid[j-1];
      assign lo_lt    = cell_lt[j-1];
      assign lo_w     = cell_w[j-1];
      assign lo_id    = cell_id[j-1];
    end
    if (j == CELLS - 1) begin : g_top
      assign up_valid = 1'b0;
      assign up_w     = '0;
      assign up_id    = '0;
    end else begin : g_low
      assign up_valid = cell_valid[j+1];
      assign up_w     = cell_w[j+1];
      assign up_id    = cell_id[j+1];
    end
    hcb_cell #(.W_W(W_W), .ID_W(ID_W)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .new_weight  (new_w),
      .new_id      (new_id),
      .lower_valid (lo_valid),
      .lower_weight(lo_w),
      .lower_id    (lo_id),
      .lower_lt    (lo_lt),
      .upper_valid (up_valid),
      .upper_weight(up_w),
      .upper_id    (up_id),
      .valid       (cell_valid[j]),
      .weight      (cell_w[j]),
      .id          (cell_id[j]),
      .lt          (cell_lt[j])
    );
  end

  hcb_ram #(.WIDTH(ID_W + 2), .DEPTH(NODE_DEPTH)) u_link_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(cell_id[0]),
    .wr_data({nxt, k}),
    .rd_en  (ram_re),
    .rd_addr(nd),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_HOLD;
    new_w      = '0;
    new_id     = '0;
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          if (room) begin
            cmd    = CMD_INSERT;
            new_w  = W_W'(in_data.weight);
            new_id = ID_W'(count);
          end
          if (in_data.last_symbol) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (pad) begin
          cmd    = CMD_INSERT;
          new_id = ID_W'(count);
        end
        state_next = S_SNAP;
      end
      S_SNAP: begin
        state_next = (leaves >= CNT_W'(group)) ? S_MERGE : S_ROOT;
      end
      S_MERGE: begin
        cmd = CMD_POP;
        if (k == group - 2'd1) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd        = CMD_INSERT;
        new_w      = sum;
        new_id     = nxt;
        state_next = (cnt + CNT_W'(1) >= CNT_W'(group)) ? S_MERGE : S_ROOT;
      end
      S_ROOT: begin
        state_next = S_NEXT;
      end
      S_NEXT: begin
        state_next = (count == CNT_W'(1)) ? S_OUT : S_WALK;
      end
      S_WALK: begin
        state_next = walk_done ? S_OUT : S_STEP;
      end
      S_STEP: begin
        state_next = S_WALK;
      end
      S_OUT: begin
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready) begin
          if (last_emit) begin
            cmd        = CMD_CLEAR;
            state_next = S_LOAD;
          end else begin
            state_next = S_NEXT;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= RADIX_RESET;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        radix <= cfg_data;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_PAD: begin
          leaves <= pad ? count + CNT_W'(1) : count;
        end
        S_SNAP: begin
          for (int j = 0; j < MAX_SYMBOLS; j++) begin
            emit_id[j] <= pad ? cell_id[j+1] : cell_id[j];
          end
          cnt  <= leaves;
          nxt  <= ID_W'(leaves);
          k    <= '0;
          sum  <= '0;
          epos <= POS_W'(count - CNT_W'(1));
          em   <= '0;
        end
        S_MERGE: begin
          sum <= sum + cell_w[0];
          k   <= k + 2'd1;
          cnt <= cnt - CNT_W'(1);
        end
        S_PUSH: begin
          nxt <= nxt + ID_W'(1);
          cnt <= cnt + CNT_W'(1);
          k   <= '0;
          sum <= '0;
        end
        S_ROOT: begin
          root <= cell_id[0];
        end
        S_NEXT: begin
          nd   <= emit_id[epos];
          code <= '0;
          len  <= (count == CNT_W'(1)) ? LEN_LONE : '0;
        end
        S_STEP: begin
          code <= code | (CODE_W'(digit) << shift);
          len  <= len + LEN_W'(1);
          nd   <= parent;
        end
        S_OUT: begin
          out_valid             <= 1'b1;
          out_data.symbol_index <= IDX_W'(emit_id[epos]);
          out_data.code_length  <= len;
          out_data.codeword     <= code;
          out_data.overflow     <= ovf;
          out_data.last_result  <= last_emit;
        end
        S_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_emit) begin
              count <= '0;
              ovf   <= 1'b0;
            end else begin
              em   <= em + CNT_W'(1);
              epos <= epos - POS_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.code_length != '0))
    else $error("result with zero code length");

  a_chain_packed: assert property (@(posedge clk) disable iff (rst)
    (CELLS'(cell_valid + CELLS'(1)) & cell_valid) == '0)
    else $error("cell chain has a gap");

  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last_result) |=> in_ready)
    else $error("input not reopened after last result");

  a_merge_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> cell_valid[0])
    else $error("merge pops an empty chain");

endmodule

[rtl/hcb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/hcb_cell.sv]
// One cell of the ascending sorted node chain: holds a node weight and id.
module hcb_cell #(
  parameter int W_W  = 21,
  parameter int ID_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  hcb_pkg::cell_cmd_t cmd,
  input  logic [W_W-1:0]    new_weight,
  input  logic [ID_W-1:0]   new_id,
  input  logic              lower_valid,
  input  logic [W_W-1:0]    lower_weight,
  input  logic [ID_W-1:0]   lower_id,
  input  logic              lower_lt,
  input  logic              upper_valid,
  input  logic [W_W-1:0]    upper_weight,
  input  logic [ID_W-1:0]   upper_id,
  output logic              valid,
  output logic [W_W-1:0]    weight,
  output logic [ID_W-1:0]   id,
  output logic              lt
);

  import hcb_pkg::*;

  assign lt = valid && (weight < new_weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd)
        CMD_CLEAR: begin
          valid <= 1'b0;
        end
        CMD_POP: begin
          valid  <= upper_valid;
          weight <= upper_weight;
          id     <= upper_id;
        end
        CMD_INSERT: begin
          if (!lt) begin
            if (lower_lt) begin
              valid  <= 1'b1;
              weight <= new_weight;
              id     <= new_id;
            end else begin
              valid  <= lower_valid;
              weight <= lower_weight;
              id     <= lower_id;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
